/* rtl/aeos_pkg.sv */
// Shared types and constants for the array edit op stream decoder.
package aeos_pkg;

    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 56;
    localparam int HDR_OP_W  = 8;
    localparam int OPCODE_W  = 4;
    localparam int LIT_IDX_W = 16;
    localparam int CFG_W     = 17;

    // Highest opcode with a defined meaning
    localparam logic [HDR_OP_W-1:0] OPCODE_MAX = 8'd9;

    // Opcodes carried in the header word
    localparam logic [OPCODE_W-1:0] OPC_WRITELIT      = 4'd0;
    localparam logic [OPCODE_W-1:0] OPC_WRITEREF      = 4'd1;
    localparam logic [OPCODE_W-1:0] OPC_INSERTLIT     = 4'd2;
    localparam logic [OPCODE_W-1:0] OPC_INSERTREF     = 4'd3;
    localparam logic [OPCODE_W-1:0] OPC_ERASE         = 4'd4;
    localparam logic [OPCODE_W-1:0] OPC_MINSIZE       = 4'd5;
    localparam logic [OPCODE_W-1:0] OPC_MINSIZE_FILL  = 4'd6;
    localparam logic [OPCODE_W-1:0] OPC_SETSIZE       = 4'd7;
    localparam logic [OPCODE_W-1:0] OPC_SETSIZE_FILL  = 4'd8;

    typedef enum logic [2:0] {
        KIND_WRITELIT  = 3'd0,
        KIND_WRITEREF  = 3'd1,
        KIND_INSERTLIT = 3'd2,
        KIND_INSERTREF = 3'd3,
        KIND_ERASE     = 3'd4,
        KIND_MINSIZE   = 3'd5,
        KIND_SETSIZE   = 3'd6,
        KIND_MAXSIZE   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNKNOWN_OP  = 2'd1,
        ST_TRUNCATED   = 2'd2,
        ST_LIT_RANGE   = 2'd3
    } t_status;

    // One stream word as held in the input register
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_word;
    } t_word;

    // One decoded result
    typedef struct packed {
        logic                  has_record;
        t_kind                 op_kind;
        logic [WORD_W-1:0]     first_arg;
        logic [WORD_W-1:0]     second_arg;
        logic [LIT_IDX_W-1:0]  literal_index;
        logic                  uses_literal;
        logic                  with_fill;
        logic                  end_of_stream;
        t_status               status;
    } t_result;

endpackage

/* rtl/aeos_word_if.sv */
// Input word channel: valid/ready with one stream word.
interface aeos_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] word;
    logic        last_word;

    modport source(output valid, word, last_word, input ready);
    modport sink(input valid, word, last_word, output ready);
endinterface

/* rtl/aeos_rec_if.sv */
// Result channel: valid/ready with one decoded op record.
interface aeos_rec_if;
    logic               valid;
    logic               ready;
    logic               has_record;
    logic [2:0]         op_kind;
    logic signed [63:0] first_arg;
    logic signed [63:0] second_arg;
    logic [15:0]        literal_index;
    logic               uses_literal;
    logic               with_fill;
    logic               end_of_stream;
    logic [1:0]         status;

    modport source(output valid, has_record, op_kind, first_arg, second_arg, literal_index,
                   uses_literal, with_fill, end_of_stream, status, input ready);
    modport sink(input valid, has_record, op_kind, first_arg, second_arg, literal_index,
                 uses_literal, with_fill, end_of_stream, status, output ready);
endinterface

/* rtl/aeos_cfg_if.sv */
// Configuration write channel: valid/ready with the literal count.
interface aeos_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

/* rtl/aeos_in_reg.sv */
// Input register stage for stream words.
module aeos_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  aeos_pkg::t_word i_word,
    output logic           o_ready,
    input  logic           i_take,
    output logic           o_valid,
    output aeos_pkg::t_word o_word
);

    logic            r_valid;
    aeos_pkg::t_word r_word;

    // Accept when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* rtl/aeos_decode.sv */
// Phase tracking and combinational decode of one stream word into a result.
module aeos_decode #(
    parameter int MAX_LITERALS = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_advance,
    input  aeos_pkg::t_word                    i_word,
    input  logic [aeos_pkg::CFG_W-1:0]         i_literal_count,
    output logic                               o_res_valid,
    output aeos_pkg::t_result                  o_res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OP1,
        PH_OP2,
        PH_DROP
    } t_phase;

    t_phase                               r_phase, n_phase;
    logic [aeos_pkg::OPCODE_W-1:0]        r_opcode, n_opcode;
    logic [aeos_pkg::COUNT_W-1:0]         r_groups, n_groups;
    logic [aeos_pkg::WORD_W-1:0]          r_held;

    logic [aeos_pkg::WORD_W-1:0]          w;
    logic                                 last;
    logic [aeos_pkg::HDR_OP_W-1:0]        hdr_op;
    logic [aeos_pkg::COUNT_W-1:0]         hdr_cnt;
    logic                                 two_ops;

    logic [aeos_pkg::WORD_W-1:0]          a1, a2;
    aeos_pkg::t_kind                      fin_kind;
    logic [aeos_pkg::WORD_W-1:0]          fin_f1, fin_f2, fin_lit;
    logic                                 fin_uses, fin_fill;
    logic [aeos_pkg::WORD_W-1:0]          count_ext, max_ext, lim;
    logic                                 lit_ok;
    logic [aeos_pkg::COUNT_W-1:0]         groups_dec;

    assign w       = i_word.word;
    assign last    = i_word.last_word;
    assign hdr_op  = w[aeos_pkg::WORD_W-1 -: aeos_pkg::HDR_OP_W];
    assign hdr_cnt = w[aeos_pkg::COUNT_W-1:0];
    assign two_ops = r_opcode inside {aeos_pkg::OPC_WRITELIT, aeos_pkg::OPC_WRITEREF,
                                      aeos_pkg::OPC_INSERTLIT, aeos_pkg::OPC_INSERTREF,
                                      aeos_pkg::OPC_MINSIZE_FILL, aeos_pkg::OPC_SETSIZE_FILL};

    // Operands of the group being completed
    assign a1 = (r_phase == PH_OP2) ? r_held : w;
    assign a2 = (r_phase == PH_OP2) ? w : '0;

    // Effective literal limit, clamped to the build-time maximum
    assign count_ext  = aeos_pkg::WORD_W'(i_literal_count);
    assign max_ext    = aeos_pkg::WORD_W'(MAX_LITERALS);
    assign lim        = (count_ext > max_ext) ? max_ext : count_ext;
    assign lit_ok     = !fin_lit[aeos_pkg::WORD_W-1] && (fin_lit < lim);
    assign groups_dec = r_groups - aeos_pkg::COUNT_W'(1);

    // Map opcode and operands onto record fields
    always_comb begin
        fin_kind = aeos_pkg::KIND_MAXSIZE;
        fin_f1   = '0;
        fin_f2   = '0;
        fin_lit  = '0;
        fin_uses = 1'b0;
        fin_fill = 1'b0;
        case (r_opcode)
            aeos_pkg::OPC_WRITELIT: begin
                fin_kind = aeos_pkg::KIND_WRITELIT;
                fin_f2 = a2; fin_lit = a1; fin_uses = 1'b1;
            end
            aeos_pkg::OPC_WRITEREF: begin
                fin_kind = aeos_pkg::KIND_WRITEREF;
                fin_f1 = a1; fin_f2 = a2;
            end
            aeos_pkg::OPC_INSERTLIT: begin
                fin_kind = aeos_pkg::KIND_INSERTLIT;
                fin_f2 = a2; fin_lit = a1; fin_uses = 1'b1;
            end
            aeos_pkg::OPC_INSERTREF: begin
                fin_kind = aeos_pkg::KIND_INSERTREF;
                fin_f1 = a1; fin_f2 = a2;
            end
            aeos_pkg::OPC_ERASE: begin
                fin_kind = aeos_pkg::KIND_ERASE;
                fin_f1 = a1;
            end
            aeos_pkg::OPC_MINSIZE: begin
                fin_kind = aeos_pkg::KIND_MINSIZE;
                fin_f1 = a1;
            end
            aeos_pkg::OPC_MINSIZE_FILL: begin
                fin_kind = aeos_pkg::KIND_MINSIZE;
                fin_f1 = a1; fin_fill = 1'b1; fin_lit = a2; fin_uses = 1'b1;
            end
            aeos_pkg::OPC_SETSIZE: begin
                fin_kind = aeos_pkg::KIND_SETSIZE;
                fin_f1 = a1;
            end
            aeos_pkg::OPC_SETSIZE_FILL: begin
                fin_kind = aeos_pkg::KIND_SETSIZE;
                fin_f1 = a1; fin_fill = 1'b1; fin_lit = a2; fin_uses = 1'b1;
            end
            default: begin
                fin_kind = aeos_pkg::KIND_MAXSIZE;
                fin_f1 = a1;
            end
        endcase
    end

    // Decode the word against the current phase
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_groups    = r_groups;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.end_of_stream = last;
        case (r_phase)
            PH_HEADER: begin
                if (hdr_op > aeos_pkg::OPCODE_MAX) begin
                    o_res_valid  = 1'b1;
                    o_res.status = aeos_pkg::ST_UNKNOWN_OP;
                    n_phase      = last ? PH_HEADER : PH_DROP;
                end else begin
                    n_opcode = hdr_op[aeos_pkg::OPCODE_W-1:0];
                    n_groups = hdr_cnt;
                    if (hdr_cnt == '0) begin
                        o_res_valid = last;
                    end else if (last) begin
                        o_res_valid  = 1'b1;
                        o_res.status = aeos_pkg::ST_TRUNCATED;
                    end else begin
                        n_phase = PH_OP1;
                    end
                end
            end
            PH_OP1, PH_OP2: begin
                if (r_phase == PH_OP1 && two_ops) begin
                    if (last) begin
                        o_res_valid  = 1'b1;
                        o_res.status = aeos_pkg::ST_TRUNCATED;
                        n_phase      = PH_HEADER;
                    end else begin
                        n_phase = PH_OP2;
                    end
                end else if (fin_uses && !lit_ok) begin
                    o_res_valid  = 1'b1;
                    o_res.status = aeos_pkg::ST_LIT_RANGE;
                    n_phase      = last ? PH_HEADER : PH_DROP;
                end else begin
                    o_res_valid         = 1'b1;
                    o_res.has_record    = 1'b1;
                    o_res.op_kind       = fin_kind;
                    o_res.first_arg     = fin_f1;
                    o_res.second_arg    = fin_f2;
                    o_res.literal_index = fin_lit[aeos_pkg::LIT_IDX_W-1:0];
                    o_res.uses_literal  = fin_uses;
                    o_res.with_fill     = fin_fill;
                    n_groups            = groups_dec;
                    if (last) begin
                        o_res.status = (groups_dec != '0) ? aeos_pkg::ST_TRUNCATED
                                                          : aeos_pkg::ST_OK;
                        n_phase      = PH_HEADER;
                    end else begin
                        n_phase = (groups_dec != '0) ? PH_OP1 : PH_HEADER;
                    end
                end
            end
            default: begin
                if (last) begin
                    n_phase = PH_HEADER;
                end
            end
        endcase
    end

    // Advance state when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_opcode <= '0;
            r_groups <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_groups <= n_groups;
        end
    end

    // Hold the first operand of a two-operand group
    always_ff @(posedge i_clk) begin
        if (i_advance && r_phase == PH_OP1) begin
            r_held <= w;
        end
    end

    a_last_returns_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && last) |=> (r_phase == PH_HEADER))
        else $error("phase not back to header after last word");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_DROP) |-> !o_res_valid)
        else $error("result produced while dropping");

    a_error_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == aeos_pkg::ST_UNKNOWN_OP ||
                         o_res.status == aeos_pkg::ST_LIT_RANGE)) |-> !o_res.has_record)
        else $error("error result carries a record");

    a_fill_uses_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.with_fill) |-> o_res.uses_literal)
        else $error("fill without literal");

    a_record_after_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.has_record) |->
            (r_phase == PH_OP1 || r_phase == PH_OP2))
        else $error("record produced outside operand phase");

endmodule

/* rtl/aeos_out_reg.sv */
// Result register stage feeding the output channel.
module aeos_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  aeos_pkg::t_result i_res,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output aeos_pkg::t_result o_res
);

    logic              r_valid;
    aeos_pkg::t_result r_res;

    // Free when empty or when the held word is taken this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/array_edit_op_stream_decoder_core.sv */
// A word accepted into the input register is decoded in one pass into the result
// register. Throughput: one stream word per cycle while the result register is free,
// set by the single-pass decode between the two registers; a known header with groups
// or the first of two operands gives no result word unless last. Reset clears the
// phase to expect a header, the literal count to zero and both stage valid flags.
module array_edit_op_stream_decoder_core #(
    parameter int MAX_LITERALS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aeos_word_if.sink         i_in,
    aeos_rec_if.source        o_out,
    aeos_cfg_if.sink          i_cfg
);

    logic [aeos_pkg::CFG_W-1:0] r_literal_count;
    aeos_pkg::t_word            in_word, st_word;
    logic                       st_valid;
    logic                       advance;
    logic                       res_valid;
    aeos_pkg::t_result          res, out_res;
    logic                       out_can_load;

    // Latch the literal count on each config write
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_literal_count <= '0;
        end else if (i_cfg.valid) begin
            r_literal_count <= i_cfg.data;
        end
    end

    assign in_word.word      = i_in.word;
    assign in_word.last_word = i_in.last_word;

    // Move the held word on whenever the result register can take its outcome
    assign advance = st_valid && out_can_load;

    aeos_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_word  (in_word),
        .o_ready (i_in.ready),
        .i_take  (advance),
        .o_valid (st_valid),
        .o_word  (st_word)
    );

    aeos_decode #(
        .MAX_LITERALS (MAX_LITERALS)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_word          (st_word),
        .i_literal_count (r_literal_count),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    aeos_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && res_valid),
        .i_res      (res),
        .o_can_load (out_can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (out_res)
    );

    // Drive the result channel payload
    assign o_out.has_record    = out_res.has_record;
    assign o_out.op_kind       = out_res.op_kind;
    assign o_out.first_arg     = out_res.first_arg;
    assign o_out.second_arg    = out_res.second_arg;
    assign o_out.literal_index = out_res.literal_index;
    assign o_out.uses_literal  = out_res.uses_literal;
    assign o_out.with_fill     = out_res.with_fill;
    assign o_out.end_of_stream = out_res.end_of_stream;
    assign o_out.status        = out_res.status;

endmodule

/* dv/aeos_decoder_checker.sv */
// Checker for the op stream decoder: predicts every result word and compares it field by field.
module aeos_decoder_checker
    import aeos_pkg::*;
#(
    parameter int MAX_LITERALS = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aeos_word_if i_word,
    aeos_rec_if  i_rec,
    aeos_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FIRST_OPND,
        PH_SECOND_OPND,
        PH_DROP
    } t_phase;

    // Keep the log short when the block is badly broken
    localparam int PRINT_CAP = 20;

    t_phase                phase;
    logic [OPCODE_W-1:0]   cur_opcode;
    logic [COUNT_W-1:0]    groups_left;
    logic [WORD_W-1:0]     held_opnd;
    logic [CFG_W-1:0]      literal_count;
    t_result               pending_results[$];
    int                    fail_cnt = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_cnt < PRINT_CAP) begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        end
        fail_cnt++;
    endtask

    function automatic bit takes_two(input logic [OPCODE_W-1:0] op);
        case (op)
            OPC_WRITELIT, OPC_WRITEREF, OPC_INSERTLIT, OPC_INSERTREF,
            OPC_MINSIZE_FILL, OPC_SETSIZE_FILL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Counts above the literal store size act as the store size
    function automatic bit literal_in_range(input logic [WORD_W-1:0] idx);
        longint unsigned lim;
        lim = (literal_count > MAX_LITERALS) ? longint'(MAX_LITERALS) : longint'(literal_count);
        return !idx[WORD_W-1] && (idx < lim);
    endfunction

    // Flag an error; drop the rest of the stream unless this is its last word
    function automatic bit flag_error(input t_status st, input bit last, inout t_result res);
        res.status        = st;
        res.end_of_stream = last;
        phase             = last ? PH_HEADER : PH_DROP;
        return 1'b1;
    endfunction

    // Build the record of one completed operand group
    function automatic bit complete_group(input logic [WORD_W-1:0] a1,
                                          input logic [WORD_W-1:0] a2,
                                          input bit last, inout t_result res);
        t_kind             kind;
        logic [WORD_W-1:0] f1;
        logic [WORD_W-1:0] f2;
        logic [WORD_W-1:0] lit;
        bit                uses;
        bit                fill;
        kind = KIND_MAXSIZE;
        f1   = '0;
        f2   = '0;
        lit  = '0;
        uses = 1'b0;
        fill = 1'b0;
        case (cur_opcode)
            OPC_WRITELIT: begin
                kind = KIND_WRITELIT;
                f2   = a2;
                lit  = a1;
                uses = 1'b1;
            end
            OPC_WRITEREF: begin
                kind = KIND_WRITEREF;
                f1   = a1;
                f2   = a2;
            end
            OPC_INSERTLIT: begin
                kind = KIND_INSERTLIT;
                f2   = a2;
                lit  = a1;
                uses = 1'b1;
            end
            OPC_INSERTREF: begin
                kind = KIND_INSERTREF;
                f1   = a1;
                f2   = a2;
            end
            OPC_ERASE: begin
                kind = KIND_ERASE;
                f1   = a1;
            end
            OPC_MINSIZE: begin
                kind = KIND_MINSIZE;
                f1   = a1;
            end
            OPC_MINSIZE_FILL: begin
                kind = KIND_MINSIZE;
                f1   = a1;
                fill = 1'b1;
                lit  = a2;
                uses = 1'b1;
            end
            OPC_SETSIZE: begin
                kind = KIND_SETSIZE;
                f1   = a1;
            end
            OPC_SETSIZE_FILL: begin
                kind = KIND_SETSIZE;
                f1   = a1;
                fill = 1'b1;
                lit  = a2;
                uses = 1'b1;
            end
            default: begin
                kind = KIND_MAXSIZE;
                f1   = a1;
            end
        endcase
        if (uses && !literal_in_range(lit)) begin
            return flag_error(ST_LIT_RANGE, last, res);
        end
        res.has_record    = 1'b1;
        res.op_kind       = kind;
        res.first_arg     = f1;
        res.second_arg    = f2;
        res.literal_index = lit[LIT_IDX_W-1:0];
        res.uses_literal  = uses;
        res.with_fill     = fill;
        groups_left       = groups_left - 1'b1;
        if (last) begin
            res.end_of_stream = 1'b1;
            res.status        = (groups_left != '0) ? ST_TRUNCATED : ST_OK;
            phase             = PH_HEADER;
        end else begin
            phase = (groups_left != '0) ? PH_FIRST_OPND : PH_HEADER;
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one stream word; return 1 when it gives a result
    function automatic bit decode_word(input logic [WORD_W-1:0] w, input bit last,
                                       output t_result res);
        logic [HDR_OP_W-1:0] op;
        logic [COUNT_W-1:0]  cnt;
        res = '0;
        case (phase)
            PH_HEADER: begin
                op  = w[WORD_W-1 -: HDR_OP_W];
                cnt = w[COUNT_W-1:0];
                if (op > OPCODE_MAX) begin
                    return flag_error(ST_UNKNOWN_OP, last, res);
                end
                cur_opcode  = op[OPCODE_W-1:0];
                groups_left = cnt;
                if (cnt == '0) begin
                    res.end_of_stream = last;
                    return last;
                end
                if (last) begin
                    return flag_error(ST_TRUNCATED, 1'b1, res);
                end
                phase = PH_FIRST_OPND;
                return 1'b0;
            end
            PH_FIRST_OPND: begin
                if (takes_two(cur_opcode)) begin
                    held_opnd = w;
                    if (last) begin
                        return flag_error(ST_TRUNCATED, 1'b1, res);
                    end
                    phase = PH_SECOND_OPND;
                    return 1'b0;
                end
                return complete_group(w, '0, last, res);
            end
            PH_SECOND_OPND: begin
                return complete_group(held_opnd, w, last, res);
            end
            default: begin
                if (last) begin
                    phase = PH_HEADER;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase         = PH_HEADER;
            cur_opcode    = '0;
            groups_left   = '0;
            held_opnd     = '0;
            literal_count = '0;
            pending_results.delete();
        end else begin
            // Compare a delivered result word with the oldest prediction
            if (i_rec.valid && i_rec.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with none pending", i_rec.first_arg, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_rec.has_record !== want.has_record)
                        report_mismatch("has_record", i_rec.has_record, want.has_record);
                    if (i_rec.op_kind !== want.op_kind)
                        report_mismatch("op_kind", i_rec.op_kind, want.op_kind);
                    if (i_rec.first_arg !== want.first_arg)
                        report_mismatch("first_arg", i_rec.first_arg, want.first_arg);
                    if (i_rec.second_arg !== want.second_arg)
                        report_mismatch("second_arg", i_rec.second_arg, want.second_arg);
                    if (i_rec.literal_index !== want.literal_index)
                        report_mismatch("literal_index", i_rec.literal_index,
                                        want.literal_index);
                    if (i_rec.uses_literal !== want.uses_literal)
                        report_mismatch("uses_literal", i_rec.uses_literal, want.uses_literal);
                    if (i_rec.with_fill !== want.with_fill)
                        report_mismatch("with_fill", i_rec.with_fill, want.with_fill);
                    if (i_rec.end_of_stream !== want.end_of_stream)
                        report_mismatch("end_of_stream", i_rec.end_of_stream,
                                        want.end_of_stream);
                    if (i_rec.status !== want.status)
                        report_mismatch("status", i_rec.status, want.status);
                end
            end
            // Latch a written literal count
            if (i_cfg.valid && i_cfg.ready) begin
                literal_count = i_cfg.data;
            end
            // Predict the result of an accepted stream word
            if (i_word.valid && i_word.ready) begin
                if (decode_word(i_word.word, i_word.last_word, want)) begin
                    pending_results.insert(pending_results.size(), want);
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* dv/array_edit_op_stream_decoder_core_tb.sv */
// Testbench top for the op stream decoder: drives words and literal counts, gives the verdict.
module array_edit_op_stream_decoder_core_tb;
    import aeos_pkg::*;

    localparam int MAX_LITERALS    = 65536;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_GAP         = 18;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WORDS_PER_PHASE = 80;
    localparam int LIMIT           = 200000;

    localparam logic [WORD_W-1:0]  ARG_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0]  ARG_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0]  ALL_ONES  = {WORD_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    // Maxsize is the highest defined opcode
    localparam logic [HDR_OP_W-1:0] OPC_MAXSIZE  = OPCODE_MAX;
    localparam logic [HDR_OP_W-1:0] OPC_UNKNOWN  = OPCODE_MAX + 8'd1;
    localparam logic [HDR_OP_W-1:0] OPC_TOP_CODE = {HDR_OP_W{1'b1}};

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          cycle_cnt;
    int          words_sent = 0;
    bit          hold_req = 1'b0;
    bit          src_burst = 1'b0;
    bit          snk_burst = 1'b0;
    int unsigned lit_lim = 0;

    aeos_word_if word_ch();
    aeos_rec_if  rec_ch();
    aeos_cfg_if  cfg_ch();

    array_edit_op_stream_decoder_core #(
        .MAX_LITERALS(MAX_LITERALS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (word_ch),
        .o_out  (rec_ch),
        .i_cfg  (cfg_ch)
    );

    aeos_decoder_checker #(
        .MAX_LITERALS(MAX_LITERALS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_word      (word_ch),
        .i_rec       (rec_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // End the run if it hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [WORD_W-1:0] hdr(input logic [HDR_OP_W-1:0] op,
                                              input logic [COUNT_W-1:0] cnt);
        return {op, cnt};
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Size or index operand: small, small negative or full width
    function automatic logic [WORD_W-1:0] rand_arg();
        case ($urandom_range(0, 3))
            0: return WORD_W'($urandom_range(0, 64));
            1: return -(WORD_W'($urandom_range(1, 64)));
            default: return rand_word();
        endcase
    endfunction

    // Literal index: mostly in range, sometimes at the bounds or negative
    function automatic logic [WORD_W-1:0] rand_literal();
        logic [WORD_W-1:0] w;
        w = rand_word();
        w[WORD_W-1] = 1'b1;
        case ($urandom_range(0, 9))
            7: return WORD_W'(lit_lim);
            8: return WORD_W'(lit_lim) - 1'b1;
            9: return w;
            default: return (lit_lim == 0) ? '0 : WORD_W'($urandom_range(0, lit_lim - 1));
        endcase
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [WORD_W-1:0] w, input bit last);
        int gap;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.word      <= w;
        word_ch.last_word <= last;
        do @(posedge clk); while (!word_ch.ready);
        words_sent++;
    endtask

    // Stop offering words until every predicted result has arrived and the pipe is empty
    task automatic wait_idle();
        word_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_literal_count(input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        lit_lim = (val > MAX_LITERALS) ? MAX_LITERALS : val;
    endtask

    // Build one stream: mostly well formed, else cut short, unknown opcode or noise
    task automatic send_random_stream();
        t_word               q[$];
        int                  kind;
        int                  n_ops;
        int                  n_groups;
        int                  cut;
        logic [HDR_OP_W-1:0] op;
        logic [COUNT_W-1:0]  cnt;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            n_ops = $urandom_range(1, 4);
            for (int i = 0; i < n_ops; i++) q.insert(q.size(), {rand_word(), 1'b0});
        end else if (kind == 8) begin
            op  = HDR_OP_W'($urandom_range(OPC_UNKNOWN, OPC_TOP_CODE));
            cnt = COUNT_W'(rand_word());
            q.insert(q.size(), {hdr(op, cnt), 1'b0});
            n_ops = $urandom_range(0, 3);
            for (int i = 0; i < n_ops; i++) q.insert(q.size(), {rand_word(), 1'b0});
        end else begin
            n_ops = $urandom_range(1, 3);
            for (int i = 0; i < n_ops; i++) begin
                op       = HDR_OP_W'($urandom_range(0, OPC_MAXSIZE));
                n_groups = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                cnt      = COUNT_W'(n_groups);
                if (kind == 7 && $urandom_range(0, 2) == 0) cnt = COUNT_W'(rand_word());
                q.insert(q.size(), {hdr(op, cnt), 1'b0});
                for (int g = 0; g < n_groups; g++) begin
                    case (op[OPCODE_W-1:0])
                        OPC_WRITELIT, OPC_INSERTLIT: begin
                            q.insert(q.size(), {rand_literal(), 1'b0});
                            q.insert(q.size(), {rand_arg(), 1'b0});
                        end
                        OPC_WRITEREF, OPC_INSERTREF: begin
                            q.insert(q.size(), {rand_arg(), 1'b0});
                            q.insert(q.size(), {rand_arg(), 1'b0});
                        end
                        OPC_MINSIZE_FILL, OPC_SETSIZE_FILL: begin
                            q.insert(q.size(), {rand_arg(), 1'b0});
                            q.insert(q.size(), {rand_literal(), 1'b0});
                        end
                        default: begin
                            q.insert(q.size(), {rand_arg(), 1'b0});
                        end
                    endcase
                end
            end
            // Cut the stream short at a random word
            if (kind == 7) begin
                cut = $urandom_range(0, q.size() - 1);
                while (q.size() > cut + 1) void'(q.pop_back());
            end
        end
        q[q.size() - 1].last_word = 1'b1;
        foreach (q[i]) send_word(q[i].word, q[i].last_word);
    endtask

    // Result side: random stalls, with a long hold-off on request
    initial begin
        int stall;
        rec_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                rec_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rec_ch.ready <= 1'b1;
            do @(posedge clk); while (!rec_ch.valid);
        end
    end

    // Word side: reset, directed words, then random phases over several literal counts
    initial begin
        logic [CFG_W-1:0] lit_settings [7];
        int               target;
        lit_settings = '{17'h1FFFF, 17'd65536, 17'd1, 17'd0, 17'd0, 17'd65535, 17'd5};
        lit_settings[4] = CFG_W'($urandom_range(2, 4000));
        rst_n             <= 1'b0;
        word_ch.valid     <= 1'b0;
        word_ch.word      <= '0;
        word_ch.last_word <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Run a few streams with the literal count left at its reset value
        while (words_sent < 40) send_random_stream();

        write_literal_count(17'd16);
        // Two writelit groups at the index bounds and the operand extremes
        send_word(hdr(OPC_WRITELIT, 2), 1'b0);
        send_word(64'd15, 1'b0);
        send_word(ARG_MIN, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(ARG_MAX, 1'b0);
        send_word(hdr(OPC_WRITEREF, 1), 1'b0);
        send_word(ALL_ONES, 1'b0);
        send_word(ARG_MAX, 1'b0);
        // Index equal to the literal count, then drop to the end of the stream
        send_word(hdr(OPC_INSERTLIT, 1), 1'b0);
        send_word(64'd16, 1'b0);
        send_word(ALL_ONES, 1'b0);
        send_word(hdr(OPC_INSERTREF, 1), 1'b1);
        // Negative fill literal on the last word
        send_word(hdr(OPC_MINSIZE_FILL, 1), 1'b0);
        send_word(ALL_ONES, 1'b0);
        send_word(ARG_MIN, 1'b1);
        // A fill group, then a header without groups mid-stream that gives nothing
        send_word(hdr(OPC_SETSIZE_FILL, 1), 1'b0);
        send_word(64'd5, 1'b0);
        send_word(64'd15, 1'b0);
        send_word(hdr(OPC_ERASE, 0), 1'b0);
        // Unknown opcode with a zero count, then drop
        send_word(hdr(OPC_TOP_CODE, 0), 1'b0);
        send_word(64'd0, 1'b1);
        // Group completes on the last word with groups still left
        send_word(hdr(OPC_MAXSIZE, COUNT_MAX), 1'b0);
        send_word(64'd7, 1'b1);
        // Last word as the first of two operands, and as a header with groups
        send_word(hdr(OPC_INSERTREF, 1), 1'b0);
        send_word(64'd3, 1'b1);
        send_word(hdr(OPC_MINSIZE, 3), 1'b1);
        // Empty header as the last word, and unknown opcode on the last word
        send_word(hdr(OPC_SETSIZE, 0), 1'b1);
        send_word(hdr(OPC_UNKNOWN, 0), 1'b1);

        foreach (lit_settings[i]) begin
            write_literal_count(lit_settings[i]);
            if (i == 2 || i == 5) hold_req = 1'b1;
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) send_random_stream();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
